/* hdl/jan_pkg.sv */
package jan_pkg;

  localparam int unsigned POS_BITS  = 8;
  localparam int unsigned QUOT_BITS = 7;
  localparam int unsigned IDX_BITS  = 3;

  localparam int unsigned RST_H_HIGH   = 3748;
  localparam int unsigned RST_H_LOW    = 366;
  localparam int unsigned RST_H_CENTER = 2056;
  localparam int unsigned RST_V_HIGH   = 3731;
  localparam int unsigned RST_V_LOW    = 354;
  localparam int unsigned RST_V_CENTER = 2048;
  localparam int unsigned RST_MARGIN   = 16;

  typedef enum logic [IDX_BITS-1:0] {
    IDX_H_HIGH   = 3'd0,
    IDX_H_LOW    = 3'd1,
    IDX_H_CENTER = 3'd2,
    IDX_V_HIGH   = 3'd3,
    IDX_V_LOW    = 3'd4,
    IDX_V_CENTER = 3'd5,
    IDX_MARGIN   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic       load;
    logic       axis_y;
    logic       prep;
    logic       check;
    logic       step;
    logic [2:0] step_bit;
    logic       store;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic out_busy;
  } status_t;

endpackage

/* hdl/jan_datapath.sv */
module jan_datapath
  import jan_pkg::*;
#(
  parameter int unsigned SB = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic                       cfg_we_i,
  input  logic [IDX_BITS-1:0]        cfg_idx_i,
  input  logic [SB-1:0]              cfg_data_i,
  input  logic [SB-1:0]              h_sample_i,
  input  logic [SB-1:0]              v_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [POS_BITS-1:0] x_pos_o,
  output logic signed [POS_BITS-1:0] y_pos_o,
  output logic                       moved_o
);

  localparam int unsigned NB = SB + QUOT_BITS;

  logic [SB-1:0] h_high_q, h_low_q, h_center_q;
  logic [SB-1:0] v_high_q, v_low_q, v_center_q;
  logic [SB-1:0] margin_q;
  logic [SB-1:0] last_h_q, last_v_q;
  logic [SB-1:0] h_q, v_q;
  logic          moved_q;
  logic [NB-1:0] rem_q;
  logic [SB-1:0] den_q;
  logic          neg_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic signed [POS_BITS-1:0] x_q, y_q;
  logic          out_valid_q;
  logic signed [POS_BITS-1:0] x_pos_q, y_pos_q;
  logic          moved_out_q;

  logic                 h_out, v_out, moved_now;
  logic [SB-1:0]        s, hi, lo, c;
  logic signed [SB:0]   diff, den_s;
  logic signed [SB+7:0] prod;
  logic [SB+7:0]        prod_abs;
  logic [SB:0]          den_abs;
  logic [NB-1:0]        den_top, sub;
  logic                 ovf, ge;
  logic [POS_BITS-1:0]  quot_ext, res;

  assign h_out = ({1'b0, h_sample_i} > ({1'b0, last_h_q} + {1'b0, margin_q})) ||
                 (({1'b0, h_sample_i} + {1'b0, margin_q}) < {1'b0, last_h_q});
  assign v_out = ({1'b0, v_sample_i} > ({1'b0, last_v_q} + {1'b0, margin_q})) ||
                 (({1'b0, v_sample_i} + {1'b0, margin_q}) < {1'b0, last_v_q});
  assign moved_now = h_out || v_out;

  assign s  = cmd_i.axis_y ? v_q        : h_q;
  assign hi = cmd_i.axis_y ? v_high_q   : h_high_q;
  assign lo = cmd_i.axis_y ? v_low_q    : h_low_q;
  assign c  = cmd_i.axis_y ? v_center_q : h_center_q;

  assign diff  = $signed({1'b0, s}) - $signed({1'b0, c});
  assign prod  = $signed({diff, 7'b0}) - $signed({{7{diff[SB]}}, diff});
  assign den_s = (s >= c) ? $signed({1'b0, hi} - {1'b0, c})
                          : $signed({1'b0, c} - {1'b0, lo});
  assign prod_abs = prod[SB+7] ? (~prod + 1'b1) : prod;
  assign den_abs  = den_s[SB] ? (~den_s + 1'b1) : den_s;

  assign den_top = {den_q, {QUOT_BITS{1'b0}}};
  assign ovf     = (rem_q >= den_top) && (rem_q != '0);
  assign sub     = NB'(den_q) << cmd_i.step_bit;
  assign ge      = (rem_q >= sub) && (den_q != '0);

  assign quot_ext = {1'b0, quot_q};
  assign res      = neg_q ? (~quot_ext + 1'b1) : quot_ext;

  assign status_o.ovf      = ovf;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_high_q   <= SB'(RST_H_HIGH);
      h_low_q    <= SB'(RST_H_LOW);
      h_center_q <= SB'(RST_H_CENTER);
      v_high_q   <= SB'(RST_V_HIGH);
      v_low_q    <= SB'(RST_V_LOW);
      v_center_q <= SB'(RST_V_CENTER);
      margin_q   <= SB'(RST_MARGIN);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        IDX_H_HIGH:   h_high_q   <= cfg_data_i;
        IDX_H_LOW:    h_low_q    <= cfg_data_i;
        IDX_H_CENTER: h_center_q <= cfg_data_i;
        IDX_V_HIGH:   v_high_q   <= cfg_data_i;
        IDX_V_LOW:    v_low_q    <= cfg_data_i;
        IDX_V_CENTER: v_center_q <= cfg_data_i;
        IDX_MARGIN:   margin_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_h_q <= SB'(RST_H_CENTER);
      last_v_q <= SB'(RST_V_CENTER);
    end else if (cmd_i.load && moved_now) begin
      last_h_q <= h_sample_i;
      last_v_q <= v_sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q     <= h_sample_i;
      v_q     <= v_sample_i;
      moved_q <= moved_now;
    end
    if (cmd_i.prep) begin
      rem_q  <= prod_abs[NB-1:0];
      den_q  <= den_abs[SB-1:0];
      neg_q  <= prod[SB+7] ^ den_s[SB];
      quot_q <= '0;
    end else if (cmd_i.check) begin
      if (ovf) begin
        quot_q <= '1;
      end
    end else if (cmd_i.step) begin
      quot_q <= {quot_q[QUOT_BITS-2:0], ge};
      if (ge) begin
        rem_q <= rem_q - sub;
      end
    end
    if (cmd_i.store) begin
      if (cmd_i.axis_y) begin
        y_q <= $signed(res);
      end else begin
        x_q <= $signed(res);
      end
    end
    if (cmd_i.publish) begin
      x_pos_q     <= x_q;
      y_pos_q     <= y_q;
      moved_out_q <= moved_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_pos_o     = x_pos_q;
  assign y_pos_o     = y_pos_q;
  assign moved_o     = moved_out_q;

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> out_valid_o)
    else $error("result not presented after publish");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (x_pos_o != -8'sd128) && (y_pos_o != -8'sd128))
    else $error("position outside clamp range");

  a_last_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && moved_now) |=>
      (last_h_q == $past(h_sample_i)) && (last_v_q == $past(v_sample_i)))
    else $error("stored sample not updated on move");

endmodule

/* hdl/jan_ctrl.sv */
module jan_ctrl
  import jan_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } state_e;

  state_e     state_q;
  logic       axis_q;
  logic [2:0] cnt_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.axis_y   = axis_q;
    cmd_o.step_bit = cnt_q;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.check    = (state_q == ST_CHECK);
    cmd_o.step     = (state_q == ST_DIV);
    cmd_o.store    = (state_q == ST_STORE);
    cmd_o.publish  = (state_q == ST_FINISH) && !status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            axis_q  <= 1'b0;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          cnt_q   <= 3'(QUOT_BITS - 1);
          state_q <= status_i.ovf ? ST_STORE : ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 3'd1;
          if (cnt_q == '0) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (axis_q) begin
            state_q <= ST_FINISH;
          end else begin
            axis_q  <= 1'b1;
            state_q <= ST_PREP;
          end
        end
        ST_FINISH: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_ready_after_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(cmd_o.publish))
    else $error("input reopened without publishing a result");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step || cmd_o.store) |-> !in_ready_o)
    else $error("input open while dividing");

endmodule

/* hdl/joystick_axis_normalizer_unit.sv */
// Per axis: prepare, overflow check, up to 7 restoring divide steps, store.
// Both axes share one divider; a new sample is taken only after the last
// result is published, which waits while the output register is stalled.
// The output register holds a result while the next sample is taken.
// Reset (async, active low): calibration registers take their defaults, stored
// sample returns to the rest readings, no result is pending.
module joystick_axis_normalizer_unit
  import jan_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [IDX_BITS-1:0]        cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]     cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [SAMPLE_BITS-1:0]     h_sample_i,
  input  logic [SAMPLE_BITS-1:0]     v_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [POS_BITS-1:0] x_pos_o,
  output logic signed [POS_BITS-1:0] y_pos_o,
  output logic                       moved_o
);

  cmd_t    cmd;
  status_t status;

  jan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jan_datapath #(
    .SB (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .h_sample_i  (h_sample_i),
    .v_sample_i  (v_sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .moved_o     (moved_o)
  );

endmodule

/* verif/joystick_norm_checker.sv */
module joystick_norm_checker
  import jan_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [IDX_BITS-1:0]        cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]     cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [SAMPLE_BITS-1:0]     h_sample_i,
  input  logic [SAMPLE_BITS-1:0]     v_sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [POS_BITS-1:0] x_pos_i,
  input  logic signed [POS_BITS-1:0] y_pos_i,
  input  logic                       moved_i,
  output int                         mismatch_cnt_o,
  output int                         pending_o
);

  localparam int    NUM_CAL    = int'(IDX_MARGIN) + 1;
  localparam longint FULL_SCALE = 127;

  typedef struct packed {
    logic signed [POS_BITS-1:0] x_pos;
    logic signed [POS_BITS-1:0] y_pos;
    logic                       moved;
  } joy_pos_t;

  logic [SAMPLE_BITS-1:0] cal_reg [NUM_CAL];
  logic [SAMPLE_BITS-1:0] stored_h;
  logic [SAMPLE_BITS-1:0] stored_v;
  joy_pos_t               expected_pos_q [$];
  joy_pos_t               due;

  function automatic logic signed [POS_BITS-1:0] normalise_axis(
    input logic [SAMPLE_BITS-1:0] s,
    input logic [SAMPLE_BITS-1:0] hi,
    input logic [SAMPLE_BITS-1:0] lo,
    input logic [SAMPLE_BITS-1:0] c
  );
    longint num;
    longint den;
    longint q;
    num = (longint'(s) - longint'(c)) * FULL_SCALE;
    if (s >= c) begin
      den = longint'(hi) - longint'(c);
    end else begin
      den = longint'(c) - longint'(lo);
    end
    if (den == 0) begin
      q = (num > 0) ? FULL_SCALE : (num < 0) ? -FULL_SCALE : 0;
    end else begin
      q = num / den;
      if (q > FULL_SCALE) q = FULL_SCALE;
      if (q < -FULL_SCALE) q = -FULL_SCALE;
    end
    return POS_BITS'(q);
  endfunction

  function automatic logic left_margin(
    input logic [SAMPLE_BITS-1:0] s,
    input logic [SAMPLE_BITS-1:0] prev,
    input logic [SAMPLE_BITS-1:0] margin
  );
    longint a;
    longint p;
    longint m;
    a = longint'(s);
    p = longint'(prev);
    m = longint'(margin);
    return (a > p + m) || (a < p - m);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_reg[IDX_H_HIGH]   = SAMPLE_BITS'(RST_H_HIGH);
      cal_reg[IDX_H_LOW]    = SAMPLE_BITS'(RST_H_LOW);
      cal_reg[IDX_H_CENTER] = SAMPLE_BITS'(RST_H_CENTER);
      cal_reg[IDX_V_HIGH]   = SAMPLE_BITS'(RST_V_HIGH);
      cal_reg[IDX_V_LOW]    = SAMPLE_BITS'(RST_V_LOW);
      cal_reg[IDX_V_CENTER] = SAMPLE_BITS'(RST_V_CENTER);
      cal_reg[IDX_MARGIN]   = SAMPLE_BITS'(RST_MARGIN);
      stored_h              = SAMPLE_BITS'(RST_H_CENTER);
      stored_v              = SAMPLE_BITS'(RST_V_CENTER);
      expected_pos_q.delete();
      pending_o             = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pos_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: result transfer with none expected: x_pos %0d y_pos %0d moved %0b",
                   $time, x_pos_i, y_pos_i, moved_i);
        end else begin
          due = expected_pos_q.pop_front();
          if (x_pos_i !== due.x_pos) begin
            mismatch_cnt_o++;
            $display("%0t: x_pos expected %0d actual %0d", $time, due.x_pos, x_pos_i);
          end
          if (y_pos_i !== due.y_pos) begin
            mismatch_cnt_o++;
            $display("%0t: y_pos expected %0d actual %0d", $time, due.y_pos, y_pos_i);
          end
          if (moved_i !== due.moved) begin
            mismatch_cnt_o++;
            $display("%0t: moved expected %0b actual %0b", $time, due.moved, moved_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due.x_pos = normalise_axis(h_sample_i, cal_reg[IDX_H_HIGH], cal_reg[IDX_H_LOW],
                                   cal_reg[IDX_H_CENTER]);
        due.y_pos = normalise_axis(v_sample_i, cal_reg[IDX_V_HIGH], cal_reg[IDX_V_LOW],
                                   cal_reg[IDX_V_CENTER]);
        due.moved = left_margin(h_sample_i, stored_h, cal_reg[IDX_MARGIN]) ||
                    left_margin(v_sample_i, stored_v, cal_reg[IDX_MARGIN]);
        if (due.moved) begin
          stored_h = h_sample_i;
          stored_v = v_sample_i;
        end
        expected_pos_q.push_back(due);
      end
      if (cfg_we_i && (cfg_idx_i <= IDX_MARGIN)) begin
        cal_reg[cfg_idx_i] = cfg_data_i;
      end
      pending_o = expected_pos_q.size();
    end
  end

endmodule

/* verif/tb.sv */
module tb;
  import jan_pkg::*;

  localparam int unsigned SAMPLE_BITS     = 12;
  localparam int          SMAX            = (1 << SAMPLE_BITS) - 1;
  localparam int          NUM_CAL         = int'(IDX_MARGIN) + 1;
  localparam int          CLK_PERIOD      = 12;
  localparam int          NUM_PHASES      = 8;
  localparam int          PHASE_ITEMS     = 240;
  localparam int          SETTLE_CYCLES   = 30;
  localparam int          HOLD_OFF_CYCLES = 400;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [IDX_BITS-1:0]        cfg_idx_i;
  logic [SAMPLE_BITS-1:0]     cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [SAMPLE_BITS-1:0]     h_sample_i;
  logic [SAMPLE_BITS-1:0]     v_sample_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [POS_BITS-1:0] x_pos_o;
  logic signed [POS_BITS-1:0] y_pos_o;
  logic                       moved_o;

  int                     mismatch_cnt;
  int                     pending;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     hold_off_req;
  logic [SAMPLE_BITS-1:0] cal_set [NUM_CAL];
  logic [SAMPLE_BITS-1:0] prev_h;
  logic [SAMPLE_BITS-1:0] prev_v;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  joystick_axis_normalizer_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .h_sample_i (h_sample_i),
    .v_sample_i (v_sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .x_pos_o    (x_pos_o),
    .y_pos_o    (y_pos_o),
    .moved_o    (moved_o)
  );

  joystick_norm_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .h_sample_i    (h_sample_i),
    .v_sample_i    (v_sample_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_pos_i       (x_pos_o),
    .y_pos_i       (y_pos_o),
    .moved_i       (moved_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  task automatic send_sample(input int h, input int v);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    h_sample_i <= SAMPLE_BITS'(h);
    v_sample_i <= SAMPLE_BITS'(v);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    prev_h = SAMPLE_BITS'(h);
    prev_v = SAMPLE_BITS'(v);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_calibration();
    for (int i = 0; i < NUM_CAL; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= cal_set[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_calibration(input int hh, input int hl, input int hc,
                                 input int vh, input int vl, input int vc,
                                 input int margin);
    cal_set[IDX_H_HIGH]   = SAMPLE_BITS'(hh);
    cal_set[IDX_H_LOW]    = SAMPLE_BITS'(hl);
    cal_set[IDX_H_CENTER] = SAMPLE_BITS'(hc);
    cal_set[IDX_V_HIGH]   = SAMPLE_BITS'(vh);
    cal_set[IDX_V_LOW]    = SAMPLE_BITS'(vl);
    cal_set[IDX_V_CENTER] = SAMPLE_BITS'(vc);
    cal_set[IDX_MARGIN]   = SAMPLE_BITS'(margin);
  endtask

  task automatic choose_calibration(input int phase);
    int hc;
    int vc;
    hc = $urandom_range(SMAX - 1, 1);
    vc = $urandom_range(SMAX - 1, 1);
    case (phase)
      0: set_calibration(RST_H_HIGH, RST_H_LOW, RST_H_CENTER,
                         RST_V_HIGH, RST_V_LOW, RST_V_CENTER, RST_MARGIN);
      1: set_calibration($urandom_range(SMAX, 3000), $urandom_range(1000),
                         $urandom_range(2500, 1500), $urandom_range(SMAX, 3000),
                         $urandom_range(1000), $urandom_range(2500, 1500),
                         $urandom_range(64));
      2: set_calibration(0, 0, 0, 0, 0, 0, 0);
      3: set_calibration(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
      4: set_calibration($urandom_range(SMAX), $urandom_range(SMAX), $urandom_range(SMAX),
                         $urandom_range(SMAX), $urandom_range(SMAX), $urandom_range(SMAX),
                         $urandom_range(SMAX));
      5: set_calibration(SMAX, 0, 0, 0, SMAX, SMAX, $urandom_range(SMAX));
      6: set_calibration(SMAX, 0, SMAX, $urandom_range(SMAX), 0, 0, 0);
      default: set_calibration(hc + 1, hc - 1, hc, vc + 1, vc - 1, vc,
                               $urandom_range(8));
    endcase
  endtask

  function automatic int pick_sample(input int center, input int prev, input int margin);
    int val;
    case ($urandom_range(9))
      0, 1, 2, 3: val = $urandom_range(SMAX);
      4, 5, 6:    val = center + int'($urandom_range(600)) - 300;
      default:    val = prev + int'($urandom_range(2 * margin + 4)) - (margin + 2);
    endcase
    if (val < 0) val = 0;
    if (val > SMAX) val = SMAX;
    return val;
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req != 0) begin
        stall_left   = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = IDX_H_HIGH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    h_sample_i    = '0;
    v_sample_i    = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 61;
    hold_off_req  = 0;
    prev_h        = '0;
    prev_v        = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_calibration(RST_H_HIGH, RST_H_LOW, RST_H_CENTER,
                    RST_V_HIGH, RST_V_LOW, RST_V_CENTER, RST_MARGIN);
    load_calibration();
    send_sample(RST_H_CENTER, RST_V_CENTER);
    send_sample(RST_H_HIGH, RST_V_HIGH);
    send_sample(RST_H_LOW, RST_V_LOW);
    send_sample(SMAX, 0);
    send_sample(0, SMAX);
    send_sample(2056, 2048);
    send_sample(2072, 2064);
    send_sample(2073, 2048);
    send_sample(2057, 2032);
    send_sample(2073, 2031);

    // zero span on both horizontal sides, inverted vertical, margin past stored sample
    settle();
    set_calibration(2000, 2000, 2000, 1000, 3500, 3000, 3000);
    load_calibration();
    send_sample(2000, 3000);
    send_sample(2001, 3001);
    send_sample(1999, 2999);
    send_sample(SMAX, 0);
    send_sample(0, SMAX);

    settle();
    set_calibration(SMAX, 0, 0, SMAX, 0, SMAX, 0);
    load_calibration();
    send_sample(0, SMAX);
    send_sample(0, SMAX);
    send_sample(1, SMAX - 1);
    send_sample(SMAX, 0);
    send_sample(2048, 2047);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      choose_calibration(p);
      load_calibration();
      send_idle_pct = (p < 3) ? 24 : (p < 6) ? 61 : 0;
      recv_idle_pct = (p < 3) ? 61 : (p < 6) ? 24 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 1 || p == 6) && n == PHASE_ITEMS / 2) begin
          hold_off_req = HOLD_OFF_CYCLES;
        end
        send_sample(pick_sample(cal_set[IDX_H_CENTER], prev_h, cal_set[IDX_MARGIN]),
                    pick_sample(cal_set[IDX_V_CENTER], prev_v, cal_set[IDX_MARGIN]));
      end
    end

    settle();
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/jan_pkg.sv
hdl/jan_datapath.sv
hdl/jan_ctrl.sv
hdl/joystick_axis_normalizer_unit.sv
verif/joystick_norm_checker.sv
verif/tb.sv
